FILE: src/nvme_queue_pair_tracker_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the queue pair tracker
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef NVME_QUEUE_PAIR_TRACKER_UNIT_MACROS_SVH
`define NVME_QUEUE_PAIR_TRACKER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NQPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NQPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/nqpt_pkg.sv
// ---------------------------------------------------------------------------
// Queue pair tracker package
// Field widths, request and register codes, and the controller command set.
// ---------------------------------------------------------------------------
package nqpt_pkg;

  localparam int CID_W    = 6;
  localparam int STATUS_W = 15;
  localparam int IDX_W    = 8;
  localparam int SIZE_W   = 9;
  localparam int CNT_W    = 9;
  localparam int CFG_IDX_W = 1;

  // Request kinds carried in the cmd field.
  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_COMPL  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SQ_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CQ_SIZE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming request
    logic scan;   // register the per-group free slot summaries
    logic exec;   // update queue state and load the result register
  } dp_cmd_t;

endpackage

FILE: src/nqpt_in_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one submit or completion request.
// ---------------------------------------------------------------------------
interface nqpt_in_if
  import nqpt_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [CID_W-1:0]    entry_cid;
  logic                entry_phase;
  logic [STATUS_W-1:0] entry_status;

  modport source (output valid, cmd, entry_cid, entry_phase, entry_status,
                  input ready);
  modport sink (input valid, cmd, entry_cid, entry_phase, entry_status,
                output ready);
endinterface

FILE: src/nqpt_out_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result per request.
// ---------------------------------------------------------------------------
interface nqpt_out_if
  import nqpt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic [CID_W-1:0] slot_cid;
  logic             queue_full;
  logic             cmd_ok;
  logic             stray_completion;
  logic             sq_doorbell_write;
  logic [IDX_W-1:0] sq_tail_value;
  logic             cq_doorbell_write;
  logic [IDX_W-1:0] cq_head_value;

  modport source (output valid, accepted, slot_cid, queue_full, cmd_ok,
                  stray_completion, sq_doorbell_write, sq_tail_value,
                  cq_doorbell_write, cq_head_value,
                  input ready);
  modport sink (input valid, accepted, slot_cid, queue_full, cmd_ok,
                stray_completion, sq_doorbell_write, sq_tail_value,
                cq_doorbell_write, cq_head_value,
                output ready);
endinterface

FILE: src/nqpt_datapath.sv
// ---------------------------------------------------------------------------
// Queue pair tracker datapath
// Slot map, queue indexes, phase tracking, free slot search and result register.
// ---------------------------------------------------------------------------
`include "nvme_queue_pair_tracker_unit_macros.svh"

module nqpt_datapath
  import nqpt_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd_i,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  input  logic                 req_cmd,
  input  logic [CID_W-1:0]     req_cid,
  input  logic                 req_phase,
  input  logic [STATUS_W-1:0]  req_status,
  output logic                 res_accepted,
  output logic [CID_W-1:0]     res_slot_cid,
  output logic                 res_queue_full,
  output logic                 res_cmd_ok,
  output logic                 res_stray,
  output logic                 res_sq_db,
  output logic [IDX_W-1:0]     res_sq_tail,
  output logic                 res_cq_db,
  output logic [IDX_W-1:0]     res_cq_head
);

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GW   = 8;
  localparam int NG   = (SLOTS + GW - 1) / GW;
  localparam int GIW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int PADN = NG * GW;
  localparam int EW   = 9;

  // Clamp a size register into the legal range of two to 256 entries.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s < SIZE_W'(2)) r = SIZE_W'(2);
    else if (s > SIZE_W'(256)) r = SIZE_W'(256);
    return r;
  endfunction

  // Step a ring index, wrapping to zero at the clamped size.
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] n;
    n = {1'b0, idx} + SIZE_W'(1);
    if (n >= clamp_size(size)) n = '0;
    return n[IDX_W-1:0];
  endfunction

  // Captured request.
  logic                cmd_r;
  logic [CID_W-1:0]    cid_r;
  logic                phase_r;
  logic [STATUS_W-1:0] status_r;

  // Queue state.
  logic [SLOTS-1:0]    busy_r, busy_nxt;
  logic [IDX_W-1:0]    sq_tail_r, sq_tail_nxt;
  logic [IDX_W-1:0]    cq_head_r, cq_head_nxt;
  logic                exp_phase_r, exp_phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]   sq_size_r, cq_size_r;

  // Search summaries per group of eight slots.
  logic [PADN-1:0]     padded;
  logic [NG-1:0]       grp_free, grp_free_r;
  logic [2:0]          grp_low [NG];
  logic [2:0]          grp_low_r [NG];

  // Result register.
  logic                accepted_r, accepted_nxt;
  logic [CID_W-1:0]    slot_r, slot_nxt;
  logic                full_r, full_nxt;
  logic                ok_r, ok_nxt;
  logic                stray_r, stray_nxt;
  logic                sq_db_r, sq_db_nxt;
  logic                cq_db_r, cq_db_nxt;

  // Working values for the update.
  logic [GIW-1:0]      sel_grp;
  logic                found;
  logic [EW-1:0]       free_idx;
  logic [EW-1:0]       cid_ext;
  logic                cid_busy;

  // Pad the slot map to whole groups; pad bits read as busy.
  for (genvar b = 0; b < PADN; b++) begin : g_pad
    if (b < SLOTS) begin : g_real
      assign padded[b] = busy_r[b];
    end else begin : g_fill
      assign padded[b] = 1'b1;
    end
  end

  // Lowest free slot inside each group.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_free[g] = ~&padded[g*GW +: GW];
      grp_low[g]  = '0;
      for (int k = GW - 1; k >= 0; k--) begin
        if (!padded[g*GW + k]) grp_low[g] = 3'(k);
      end
    end
  end

  // Request capture and search summary registers.
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r    <= req_cmd;
      cid_r    <= req_cid;
      phase_r  <= req_phase;
      status_r <= req_status;
    end
    if (cmd_i.scan) begin
      grp_free_r <= grp_free;
      grp_low_r  <= grp_low;
    end
  end

  // Pick the lowest group that still has a free slot.
  always_comb begin
    sel_grp = '0;
    found   = 1'b0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_free_r[g]) begin
        sel_grp = GIW'(g);
        found   = 1'b1;
      end
    end
    free_idx = (EW'(sel_grp) << 3) | EW'(grp_low_r[sel_grp]);
  end

  // Completion slot lookup; ids at or past SLOTS are never busy.
  always_comb begin
    cid_ext  = EW'(cid_r);
    cid_busy = (cid_ext < EW'(SLOTS)) && busy_r[cid_ext[IW-1:0]];
  end

  // Next queue state and result for the captured request.
  always_comb begin
    busy_nxt      = busy_r;
    sq_tail_nxt   = sq_tail_r;
    cq_head_nxt   = cq_head_r;
    exp_phase_nxt = exp_phase_r;
    cnt_nxt       = cnt_r;
    accepted_nxt  = 1'b0;
    slot_nxt      = '0;
    full_nxt      = 1'b0;
    ok_nxt        = 1'b0;
    stray_nxt     = 1'b0;
    sq_db_nxt     = 1'b0;
    cq_db_nxt     = 1'b0;
    if (cmd_r == CMD_SUBMIT) begin
      if (found) begin
        busy_nxt[free_idx[IW-1:0]] = 1'b1;
        slot_nxt     = free_idx[CID_W-1:0];
        accepted_nxt = 1'b1;
        sq_tail_nxt  = advance(sq_tail_r, sq_size_r);
        sq_db_nxt    = 1'b1;
      end else begin
        full_nxt = 1'b1;
      end
    end else if (phase_r == exp_phase_r) begin
      if (cid_busy) begin
        busy_nxt[cid_ext[IW-1:0]] = 1'b0;
      end else begin
        stray_nxt = 1'b1;
      end
      accepted_nxt = 1'b1;
      slot_nxt     = cid_r;
      ok_nxt       = (status_r == '0);
      cq_head_nxt  = advance(cq_head_r, cq_size_r);
      if (cq_head_nxt == '0) exp_phase_nxt = ~exp_phase_r;
      if (cnt_r != '1) cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cq_db_nxt = (cnt_r != '0);
      cnt_nxt   = '0;
    end
  end

  // Queue state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      sq_tail_r   <= '0;
      cq_head_r   <= '0;
      exp_phase_r <= 1'b1;
      cnt_r       <= '0;
      sq_size_r   <= SIZE_W'(64);
      cq_size_r   <= SIZE_W'(256);
    end else begin
      if (cmd_i.exec) begin
        busy_r      <= busy_nxt;
        sq_tail_r   <= sq_tail_nxt;
        cq_head_r   <= cq_head_nxt;
        exp_phase_r <= exp_phase_nxt;
        cnt_r       <= cnt_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SQ_SIZE: sq_size_r <= cfg_wdata;
          REG_CQ_SIZE: cq_size_r <= cfg_wdata;
          default:     ;
        endcase
      end
    end
  end

  // Result register, loaded once per request.
  always_ff @(posedge clk) begin
    if (cmd_i.exec) begin
      accepted_r <= accepted_nxt;
      slot_r     <= slot_nxt;
      full_r     <= full_nxt;
      ok_r       <= ok_nxt;
      stray_r    <= stray_nxt;
      sq_db_r    <= sq_db_nxt;
      cq_db_r    <= cq_db_nxt;
    end
  end

  assign res_accepted   = accepted_r;
  assign res_slot_cid   = slot_r;
  assign res_queue_full = full_r;
  assign res_cmd_ok     = ok_r;
  assign res_stray      = stray_r;
  assign res_sq_db      = sq_db_r;
  assign res_sq_tail    = sq_tail_r;
  assign res_cq_db      = cq_db_r;
  assign res_cq_head    = cq_head_r;

  // A granted submit marks exactly one more slot busy.
  `NQPT_ASSERT_NEXT(a_submit_takes_one, cmd_i.exec && cmd_r == CMD_SUBMIT && found,
    $countones(busy_r) == $countones($past(busy_r)) + 1, "submit did not take one slot")

  // A phase mismatch always closes the batch.
  `NQPT_ASSERT_NEXT(a_batch_cleared,
    cmd_i.exec && cmd_r == CMD_COMPL && phase_r != exp_phase_r,
    cnt_r == '0, "batch count not cleared on phase mismatch")

endmodule

FILE: src/nqpt_ctrl.sv
// ---------------------------------------------------------------------------
// Queue pair tracker controller
// Sequences capture, slot search and update for one request at a time.
// ---------------------------------------------------------------------------
`include "nvme_queue_pair_tracker_unit_macros.svh"

module nqpt_ctrl
  import nqpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   exec_fire;

  // Handshake decode; no request is taken while reset is held.
  always_comb begin
    in_ready  = (state_r == ST_IDLE) && rst_n;
    in_fire   = in_ready && in_valid;
    exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  end

  // Next state and result valid flag.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign cmd_o.load = in_fire;
  assign cmd_o.scan = (state_r == ST_SCAN);
  assign cmd_o.exec = exec_fire;

  `NQPT_ASSERT_NEXT(a_accept_starts_scan, in_fire, state_r == ST_SCAN,
    "accepted request did not start a search")

  `NQPT_ASSERT_NEXT(a_scan_then_exec, state_r == ST_SCAN, state_r == ST_EXEC,
    "search not followed by update")

  `NQPT_ASSERT_NEXT(a_exec_gives_result, exec_fire, out_valid_r && state_r == ST_IDLE,
    "update did not present a result")

endmodule

FILE: src/nvme_queue_pair_tracker_unit.sv
// ---------------------------------------------------------------------------
// NVMe queue pair tracker
// Host-side slot and index bookkeeping for one submission/completion pair.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per handshake: a submit (cmd 0) or an observed
//   completion entry (cmd 1). out_ch returns exactly one result per request,
//   in order, with the assigned or released slot, status flags, doorbell
//   write strobes and the current tail and head indexes.
//   cfg_we/cfg_index/cfg_wdata write sq_size (index 0) and cq_size (index 1);
//   write them only while no request is in flight.
// Timing:
//   A request is taken in the idle state, the per-group free slot summary
//   is registered in the scan state, and the update loads the result
//   register in the exec state. A new request is taken only once the
//   current one has loaded its result; the two-level slot search spans scan and exec.
// Reset and stall:
//   Synchronous reset frees every slot, zeroes both indexes, sets the
//   expected phase to one and restores the default sizes. While out_ch is
//   stalled the result holds and the next request waits in its update step.
// ---------------------------------------------------------------------------
module nvme_queue_pair_tracker_unit
  import nqpt_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  nqpt_in_if.sink              in_ch,
  nqpt_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata
);

  dp_cmd_t dp_cmd;

  // Controller: handshakes and sequencing.
  nqpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd_o     (dp_cmd)
  );

  // Datapath: queue state, slot search and result register.
  nqpt_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (dp_cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .req_cmd        (in_ch.cmd),
    .req_cid        (in_ch.entry_cid),
    .req_phase      (in_ch.entry_phase),
    .req_status     (in_ch.entry_status),
    .res_accepted   (out_ch.accepted),
    .res_slot_cid   (out_ch.slot_cid),
    .res_queue_full (out_ch.queue_full),
    .res_cmd_ok     (out_ch.cmd_ok),
    .res_stray      (out_ch.stray_completion),
    .res_sq_db      (out_ch.sq_doorbell_write),
    .res_sq_tail    (out_ch.sq_tail_value),
    .res_cq_db      (out_ch.cq_doorbell_write),
    .res_cq_head    (out_ch.cq_head_value)
  );

endmodule
